// ----- rtl/core/ohsm_pkg.sv -----
package ohsm_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD_FIRST  = 2'd0;
    localparam logic [1:0] OP_ADD_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    localparam int unsigned OP_BITS    = 2;
    localparam int unsigned ANGLE_BITS = 17;
    localparam int unsigned SHIFT_BITS = 5;
    localparam logic [ANGLE_BITS-1:0] ANGLE_SPAN = 17'd92160;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // write zero at clear address
        logic sample;       // accept sample write
        logic scan_start;   // begin a scan for current shift
        logic scan_step;    // issue one bin read
        logic shift_done;   // fold finished score into best
        logic result_load;  // capture result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic drain_done;
        logic empty;
        logic exact;
        logic last_shift;
        logic sample_busy;  // bin read-modify-write in flight
    } t_sts;

endpackage

// ----- rtl/core/ohsm_if.sv -----
interface ohsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [16:0] sample_angle;
    modport source (output valid, operation, sample_angle, input ready);
    modport sink   (input valid, operation, sample_angle, output ready);
endinterface

interface ohsm_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] best_shift;
    logic       exact_match;
    logic       empty_set;
    modport source (output valid, best_shift, exact_match, empty_set, input ready);
    modport sink   (input valid, best_shift, exact_match, empty_set, output ready);
endinterface

// ----- rtl/core/ohsm_ram.sv -----
module ohsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 720
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/ohsm_ctrl.sv -----
module ohsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ohsm_pkg::t_cmd o_cmd,
    input  ohsm_pkg::t_sts i_sts
);
    import ohsm_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_take;

    // samples and compute are taken only in idle, once the last bin update is written
    assign o_in_ready  = (r_state == ST_IDLE) && !i_sts.sample_busy;
    assign o_out_valid = r_valid;
    assign w_take      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_sts.clear_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_take && i_in_op == OP_COMPUTE) begin
                    n_state = i_sts.empty ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:  if (i_sts.scan_last) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (i_sts.drain_done) begin
                    n_state = (i_sts.exact || i_sts.last_shift) ? ST_DONE : ST_SCAN;
                end
            end
            ST_DONE: begin
                // wait for result slot to be free
                if (!r_valid || i_out_ready) n_state = ST_CLEAR;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        n_valid = r_valid && !i_out_ready;
        unique case (r_state)
            ST_CLEAR: o_cmd.clear_step = 1'b1;
            ST_IDLE: begin
                // unknown operation is taken and dropped
                o_cmd.sample = w_take &&
                               (i_in_op == OP_ADD_FIRST || i_in_op == OP_ADD_SECOND);
                o_cmd.scan_start = w_take && i_in_op == OP_COMPUTE;
            end
            ST_SCAN:  o_cmd.scan_step = 1'b1;
            ST_DRAIN: o_cmd.shift_done = i_sts.drain_done;
            ST_DONE: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.result_load = 1'b1;
                    n_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !$past(o_cmd.result_load))
        else $error("accepted input right after result load");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result_load |=> r_valid)
        else $error("result lost after load");
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result_load |=> r_state == ST_CLEAR)
        else $error("stores not cleared after compute");
`endif
endmodule

// ----- rtl/core/ohsm_dp.sv -----
module ohsm_dp #(
    parameter int BIN_COUNT  = 720,
    parameter int MAX_SHIFT  = 19,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ohsm_pkg::t_cmd                i_cmd,
    input  logic [1:0]                    i_op,
    input  logic [ohsm_pkg::ANGLE_BITS-1:0] i_angle,
    output ohsm_pkg::t_sts                o_sts,
    output logic [ohsm_pkg::SHIFT_BITS-1:0] o_best_shift,
    output logic                          o_exact_match,
    output logic                          o_empty_set
);
    import ohsm_pkg::*;

    localparam int AW   = $clog2(BIN_COUNT);
    localparam int SW   = $clog2(MAX_SHIFT + 1);
    localparam int PW   = 2 * COUNT_BITS;
    localparam int ACCW = 2 * PW + AW;
    localparam int LAT  = 4;
    localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // bin of an angle: angle*BIN_COUNT/ANGLE_SPAN by a rounded-up reciprocal,
    // exact over the whole angle range (a plain shift for half-degree bins)
    localparam int BIN_SHIFT = 34;
    localparam int MULW      = 30;
    localparam logic [63:0] BIN_MUL_WIDE =
        ((64'(BIN_COUNT) << BIN_SHIFT) + 64'(ANGLE_SPAN) - 64'd1) / 64'(ANGLE_SPAN);
    localparam logic [MULW-1:0] BIN_MUL = BIN_MUL_WIDE[MULW-1:0];

    logic [ANGLE_BITS+MULW-1:0] w_prod;
    logic [AW-1:0]              w_bin;
    assign w_prod = (ANGLE_BITS+MULW)'(i_angle) * (ANGLE_BITS+MULW)'(BIN_MUL);
    assign w_bin  = w_prod[BIN_SHIFT +: AW];

    logic [COUNT_BITS-1:0] r_tot1, r_tot2;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_i, r_j;
    logic [SW-1:0]         r_shift, r_best_shift;
    logic [ACCW-1:0]       r_acc, r_best;
    logic                  r_have, r_exact;
    logic [LAT-1:0]        r_vld;

    // sample path: read-modify-write, bin read in r_s1 and written back in r_s2
    logic                  r_s1, r_s2;
    logic                  r_set;
    logic [AW-1:0]         r_sbin;
    logic [COUNT_BITS-1:0] w_rd1, w_rd2;

    logic                  w_ok;
    logic                  w_set;
    assign w_set = (i_op == OP_ADD_SECOND);
    assign w_ok  = i_cmd.sample && (i_angle < ANGLE_SPAN) &&
                   ((w_set ? r_tot2 : r_tot1) != CMAX);

    // memory ports
    logic          w_we1, w_we2;
    logic [AW-1:0] w_wa, w_ra1, w_ra2;
    logic [COUNT_BITS-1:0] w_wd;
    always_comb begin
        w_we1 = 1'b0;
        w_we2 = 1'b0;
        w_wa  = r_sbin;
        w_wd  = (r_set ? w_rd2 : w_rd1) + COUNT_BITS'(1);
        w_ra1 = r_i;
        w_ra2 = r_j;
        if (i_cmd.clear_step) begin
            w_we1 = 1'b1;
            w_we2 = 1'b1;
            w_wa  = r_clr;
            w_wd  = '0;
        end else if (r_s2) begin
            w_we1 = !r_set;
            w_we2 = r_set;
        end
        if (r_s1) begin
            w_ra1 = r_sbin;
            w_ra2 = r_sbin;
        end
    end

    ohsm_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ram1 (
        .i_clk(i_clk), .i_we(w_we1), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra1), .o_rdata(w_rd1));
    ohsm_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ram2 (
        .i_clk(i_clk), .i_we(w_we2), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra2), .o_rdata(w_rd2));

    // score pipeline: read, cross-multiply, diff, square, accumulate
    logic [PW-1:0]   r_a, r_b, r_d;
    logic [2*PW-1:0] r_sq;
    always_ff @(posedge i_clk) begin
        r_a  <= PW'(w_rd1) * PW'(r_tot2);
        r_b  <= PW'(w_rd2) * PW'(r_tot1);
        r_d  <= (r_a > r_b) ? (r_a - r_b) : (r_b - r_a);
        r_sq <= (2*PW)'(r_d) * (2*PW)'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot1 <= '0;
            r_tot2 <= '0;
            r_clr  <= '0;
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_vld  <= '0;
        end else begin
            // clearing sweep
            if (i_cmd.clear_step) begin
                r_clr <= (r_clr == LAST_BIN) ? '0 : r_clr + AW'(1);
                if (r_clr == LAST_BIN) begin
                    r_tot1 <= '0;
                    r_tot2 <= '0;
                end
            end
            // sample update
            r_s1 <= w_ok;
            r_s2 <= r_s1;
            if (w_ok) begin
                r_set  <= w_set;
                r_sbin <= w_bin;
                if (w_set) r_tot2 <= r_tot2 + COUNT_BITS'(1);
                else       r_tot1 <= r_tot1 + COUNT_BITS'(1);
            end
            // scan control
            r_vld <= {r_vld[LAT-2:0], i_cmd.scan_step};
            if (i_cmd.scan_start) begin
                r_shift <= '0;
                r_have  <= 1'b0;
                r_exact <= 1'b0;
                r_i     <= '0;
                r_j     <= '0;
                r_acc   <= '0;
            end
            if (i_cmd.scan_step) begin
                r_i <= (r_i == LAST_BIN) ? '0 : r_i + AW'(1);
                r_j <= (r_j == LAST_BIN) ? '0 : r_j + AW'(1);
            end
            if (r_vld[LAT-1]) begin
                r_acc <= r_acc + ACCW'(r_sq);
            end
            if (i_cmd.shift_done) begin
                if (r_shift == '0) begin
                    r_exact <= (r_acc == '0);
                end else if (!r_have || r_acc < r_best) begin
                    r_best       <= r_acc;
                    r_best_shift <= r_shift;
                    r_have       <= 1'b1;
                end
                r_shift <= r_shift + SW'(1);
                r_acc   <= '0;
                r_i     <= '0;
                // second index starts at -(s+1) mod N
                r_j     <= AW'(BIN_COUNT - 1) - AW'(r_shift);
            end
        end
    end

    // drain: pipeline empty after last read
    assign o_sts.clear_last  = (r_clr == LAST_BIN);
    assign o_sts.scan_last   = (r_i == LAST_BIN);
    assign o_sts.drain_done  = (r_vld == '0);
    assign o_sts.empty       = (r_tot1 == '0) || (r_tot2 == '0);
    assign o_sts.exact       = (r_shift == '0) && (r_acc == '0);
    assign o_sts.last_shift  = (r_shift == SW'(MAX_SHIFT));
    assign o_sts.sample_busy = r_s1 || r_s2;

    // result register
    logic w_empty;
    assign w_empty = (r_tot1 == '0) || (r_tot2 == '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            o_empty_set   <= w_empty;
            o_exact_match <= !w_empty && r_exact;
            o_best_shift  <= (w_empty || r_exact) ? '0 : SHIFT_BITS'(r_best_shift);
        end
    end
endmodule

// ----- rtl/core/orientation_histogram_shift_match_top.sv -----
// channel | dir | fields
// in      | in  | operation[1:0], sample_angle[16:0]
// out     | out | best_shift[4:0], exact_match, empty_set
// A sample transfer that updates a bin drops ready while the bin is read and written back.
// A compute reads one bin pair per cycle through a five-stage multiply-square-accumulate
// pipeline for each shift from 0 to MAX_SHIFT; it ends after shift 0 on an exact match,
// and the scan is skipped when a set is empty.
// After reset and after each result load, a clearing sweep over all BIN_COUNT bins runs with ready low.
// A result not yet taken holds the next compute before its load; input waits meanwhile.
module orientation_histogram_shift_match_top #(
    parameter int BIN_COUNT  = 720,
    parameter int MAX_SHIFT  = 19,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ohsm_in_if.sink     i_in,
    ohsm_out_if.source  o_out
);
    import ohsm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ohsm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_in_op(i_in.operation), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_cmd(w_cmd), .i_sts(w_sts));

    ohsm_dp #(.BIN_COUNT(BIN_COUNT), .MAX_SHIFT(MAX_SHIFT), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_op(i_in.operation), .i_angle(i_in.sample_angle), .o_sts(w_sts),
        .o_best_shift(o_out.best_shift), .o_exact_match(o_out.exact_match),
        .o_empty_set(o_out.empty_set));
endmodule
